FILE: design/sparse_polynomial_add_unit_assert.svh
// assertion macros used by the checker file
`ifndef SPARSE_POLYNOMIAL_ADD_UNIT_ASSERT_SVH
`define SPARSE_POLYNOMIAL_ADD_UNIT_ASSERT_SVH

// antecedent holds in the same cycle as the consequent
`define SPA_ASSERT_SAME(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");

// consequent holds in the cycle after the antecedent
`define SPA_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`endif

FILE: design/spa_pkg.sv
// shared constants and types of the sparse polynomial adder
`timescale 1ns / 1ps

package spa_pkg;

  localparam int unsigned MAX_TERMS = 32;
  localparam int unsigned IDX_W     = (MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1;
  localparam int unsigned CNT_W     = $clog2(MAX_TERMS + 1);

  localparam int unsigned COEF_W = 16;
  localparam int unsigned EXPO_W = 16;
  localparam int unsigned SUM_W  = COEF_W + 1;
  localparam int unsigned TERM_W = COEF_W + EXPO_W;

  // action codes
  localparam logic [1:0] ACT_LOAD_FIRST  = 2'd0;
  localparam logic [1:0] ACT_LOAD_SECOND = 2'd1;
  localparam logic [1:0] ACT_RUN         = 2'd2;

  typedef struct packed {
    logic signed [COEF_W-1:0] coef;
    logic        [EXPO_W-1:0] expo;
  } term_t;

  typedef enum logic {
    ST_IDLE,
    ST_MERGE
  } merge_state_e;

  // top level to merge engine
  typedef struct packed {
    logic             start;
    logic [CNT_W-1:0] first_count;
    logic [CNT_W-1:0] second_count;
    logic             overflow;
  } merge_ctrl_t;

  // merge engine to top level
  typedef struct packed {
    logic idle;
    logic done;
  } merge_status_t;

endpackage

FILE: design/spa_if.sv
// handshake channels of the sparse polynomial adder
`timescale 1ns / 1ps

interface spa_req_if;
  logic               valid;
  logic               ready;
  logic [1:0]         action;
  logic signed [15:0] coefficient;
  logic [15:0]        exponent;

  modport source (output valid, output action, output coefficient, output exponent,
                  input ready);
  modport sink   (input valid, input action, input coefficient, input exponent,
                  output ready);
endinterface

interface spa_rsp_if;
  logic               valid;
  logic               ready;
  logic signed [16:0] sum_coefficient;
  logic [15:0]        result_exponent;
  logic               term_valid;
  logic               last_term;
  logic               load_overflow;

  modport source (output valid, output sum_coefficient, output result_exponent,
                  output term_valid, output last_term, output load_overflow,
                  input ready);
  modport sink   (input valid, input sum_coefficient, input result_exponent,
                  input term_valid, input last_term, input load_overflow,
                  output ready);
endinterface

FILE: design/spa_term_ram.sv
// simple dual-port term store, one write and one registered read port
`timescale 1ns / 1ps

module spa_term_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 32,
  parameter int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [WIDTH-1:0]  wdata_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [WIDTH-1:0]  rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_o <= mem[raddr_i];
  end

endmodule

FILE: design/spa_merge_engine.sv
// two-pointer merge walk over both term stores with a registered result slot
`timescale 1ns / 1ps

module spa_merge_engine (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  spa_pkg::merge_ctrl_t              ctrl_i,
  output spa_pkg::merge_status_t            status_o,
  output logic [spa_pkg::IDX_W-1:0]         first_raddr_o,
  output logic [spa_pkg::IDX_W-1:0]         second_raddr_o,
  input  spa_pkg::term_t                    first_rdata_i,
  input  spa_pkg::term_t                    second_rdata_i,
  spa_rsp_if.source                         rsp_o
);

  spa_pkg::merge_state_e state_q, state_d;

  logic [spa_pkg::CNT_W-1:0] first_idx_q, first_idx_d;
  logic [spa_pkg::CNT_W-1:0] second_idx_q, second_idx_d;
  logic [spa_pkg::CNT_W-1:0] first_nxt, second_nxt;

  logic has_first, has_second;
  logic take_first, take_second;
  logic slot_free, emit, last;

  logic                             out_valid_q, out_valid_d;
  logic signed [spa_pkg::SUM_W-1:0] out_coef_q, out_coef_d;
  logic [spa_pkg::EXPO_W-1:0]       out_expo_q, out_expo_d;
  logic                             out_term_q, out_term_d;
  logic                             out_last_q, out_last_d;
  logic                             out_ovf_q, out_ovf_d;

  logic signed [spa_pkg::SUM_W-1:0] first_ext, second_ext;

  assign slot_free = !out_valid_q || rsp_o.ready;
  assign emit      = (state_q == spa_pkg::ST_MERGE) && slot_free;

  assign has_first  = first_idx_q < ctrl_i.first_count;
  assign has_second = second_idx_q < ctrl_i.second_count;

  // pick the head with the larger exponent, both on a tie
  always_comb begin
    take_first  = 1'b0;
    take_second = 1'b0;
    if (has_first && has_second) begin
      if (first_rdata_i.expo < second_rdata_i.expo) begin
        take_second = 1'b1;
      end else if (first_rdata_i.expo > second_rdata_i.expo) begin
        take_first = 1'b1;
      end else begin
        take_first  = 1'b1;
        take_second = 1'b1;
      end
    end else if (has_first) begin
      take_first = 1'b1;
    end else if (has_second) begin
      take_second = 1'b1;
    end
  end

  assign first_nxt  = first_idx_q + spa_pkg::CNT_W'(take_first);
  assign second_nxt = second_idx_q + spa_pkg::CNT_W'(take_second);
  assign last       = (first_nxt >= ctrl_i.first_count) &&
                      (second_nxt >= ctrl_i.second_count);

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      spa_pkg::ST_IDLE: begin
        if (ctrl_i.start) begin
          state_d = spa_pkg::ST_MERGE;
        end
      end
      spa_pkg::ST_MERGE: begin
        if (emit && last) begin
          state_d = spa_pkg::ST_IDLE;
        end
      end
      default: state_d = spa_pkg::ST_IDLE;
    endcase
  end

  assign first_ext  = spa_pkg::SUM_W'(first_rdata_i.coef);
  assign second_ext = spa_pkg::SUM_W'(second_rdata_i.coef);

  // pointers and result slot
  always_comb begin
    first_idx_d  = first_idx_q;
    second_idx_d = second_idx_q;
    out_valid_d  = out_valid_q && !rsp_o.ready;
    out_coef_d   = out_coef_q;
    out_expo_d   = out_expo_q;
    out_term_d   = out_term_q;
    out_last_d   = out_last_q;
    out_ovf_d    = out_ovf_q;
    status_o.idle = 1'b0;
    status_o.done = 1'b0;
    case (state_q)
      spa_pkg::ST_IDLE: begin
        status_o.idle = 1'b1;
        first_idx_d   = '0;
        second_idx_d  = '0;
      end
      spa_pkg::ST_MERGE: begin
        if (emit) begin
          out_valid_d = 1'b1;
          out_term_d  = take_first || take_second;
          out_last_d  = last;
          out_ovf_d   = ctrl_i.overflow;
          if (take_first && take_second) begin
            out_coef_d = first_ext + second_ext;
          end else if (take_first) begin
            out_coef_d = first_ext;
          end else if (take_second) begin
            out_coef_d = second_ext;
          end else begin
            out_coef_d = '0;
          end
          if (take_first) begin
            out_expo_d = first_rdata_i.expo;
          end else if (take_second) begin
            out_expo_d = second_rdata_i.expo;
          end else begin
            out_expo_d = '0;
          end
          if (last) begin
            status_o.done = 1'b1;
            first_idx_d   = '0;
            second_idx_d  = '0;
          end else begin
            first_idx_d  = first_nxt;
            second_idx_d = second_nxt;
          end
        end
      end
      default: begin
        first_idx_d  = '0;
        second_idx_d = '0;
      end
    endcase
  end

  // read the head that will be current next cycle, so a stall re-reads the same entry
  assign first_raddr_o  = first_idx_d[spa_pkg::IDX_W-1:0];
  assign second_raddr_o = second_idx_d[spa_pkg::IDX_W-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= spa_pkg::ST_IDLE;
      first_idx_q  <= '0;
      second_idx_q <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      first_idx_q  <= first_idx_d;
      second_idx_q <= second_idx_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_coef_q <= out_coef_d;
    out_expo_q <= out_expo_d;
    out_term_q <= out_term_d;
    out_last_q <= out_last_d;
    out_ovf_q  <= out_ovf_d;
  end

  assign rsp_o.valid           = out_valid_q;
  assign rsp_o.sum_coefficient = out_coef_q;
  assign rsp_o.result_exponent = out_expo_q;
  assign rsp_o.term_valid      = out_term_q;
  assign rsp_o.last_term       = out_last_q;
  assign rsp_o.load_overflow   = out_ovf_q;

endmodule

FILE: design/sparse_polynomial_add_unit.sv
// top level of the sparse polynomial adder: term loading, fill counts and merge engine
//
//  channel | dir | payload                                                     | transfer
//  req_i   | in  | action, coefficient, exponent                               | valid & ready
//  rsp_o   | out | sum_coefficient, result_exponent, term_valid, last_term,    | valid & ready
//          |     | load_overflow                                               |
//
// a load is taken back to back while no run is in progress
// a run yields one registered result per cycle unless rsp_o stalls, once in the merge state;
// the pace is set by the single read port of each term store feeding the head compare
// req_i.ready stays low from the run transfer until the last result is registered
// an output stall holds the walk, the stalled head is re-read from the store
// reset clears fill counts, overflow flag and control; the stores hold no reset value
`timescale 1ns / 1ps

module sparse_polynomial_add_unit (
  input  logic       clk_i,
  input  logic       rst_ni,
  spa_req_if.sink    req_i,
  spa_rsp_if.source  rsp_o
);

  logic [spa_pkg::CNT_W-1:0] first_count_q, first_count_d;
  logic [spa_pkg::CNT_W-1:0] second_count_q, second_count_d;
  logic                      overflow_q, overflow_d;

  spa_pkg::merge_ctrl_t   ctrl;
  spa_pkg::merge_status_t status;

  logic xfer;
  logic load_first, load_second;
  logic run_start;
  logic we_first, we_second;
  logic first_full, second_full;

  spa_pkg::term_t               wterm;
  logic [spa_pkg::TERM_W-1:0]   first_rdata, second_rdata;
  logic [spa_pkg::IDX_W-1:0]    first_raddr, second_raddr;

  assign req_i.ready = status.idle;
  assign xfer        = req_i.valid && req_i.ready;

  assign first_full  = first_count_q >= spa_pkg::CNT_W'(spa_pkg::MAX_TERMS);
  assign second_full = second_count_q >= spa_pkg::CNT_W'(spa_pkg::MAX_TERMS);

  always_comb begin
    load_first  = 1'b0;
    load_second = 1'b0;
    run_start   = 1'b0;
    case (req_i.action)
      spa_pkg::ACT_LOAD_FIRST:  load_first  = xfer;
      spa_pkg::ACT_LOAD_SECOND: load_second = xfer;
      spa_pkg::ACT_RUN:         run_start   = xfer;
      default: ;
    endcase
  end

  assign we_first  = load_first && !first_full;
  assign we_second = load_second && !second_full;

  always_comb begin
    first_count_d  = first_count_q;
    second_count_d = second_count_q;
    overflow_d     = overflow_q;
    if (status.done) begin
      first_count_d  = '0;
      second_count_d = '0;
      overflow_d     = 1'b0;
    end else begin
      if (we_first) begin
        first_count_d = first_count_q + spa_pkg::CNT_W'(1);
      end
      if (we_second) begin
        second_count_d = second_count_q + spa_pkg::CNT_W'(1);
      end
      if ((load_first && first_full) || (load_second && second_full)) begin
        overflow_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      first_count_q  <= '0;
      second_count_q <= '0;
      overflow_q     <= 1'b0;
    end else begin
      first_count_q  <= first_count_d;
      second_count_q <= second_count_d;
      overflow_q     <= overflow_d;
    end
  end

  assign ctrl.start        = run_start;
  assign ctrl.first_count  = first_count_q;
  assign ctrl.second_count = second_count_q;
  assign ctrl.overflow     = overflow_q;

  assign wterm.coef = req_i.coefficient;
  assign wterm.expo = req_i.exponent;

  spa_term_ram #(
    .WIDTH (spa_pkg::TERM_W),
    .DEPTH (spa_pkg::MAX_TERMS)
  ) u_first_ram (
    .clk_i   (clk_i),
    .we_i    (we_first),
    .waddr_i (first_count_q[spa_pkg::IDX_W-1:0]),
    .wdata_i (wterm),
    .raddr_i (first_raddr),
    .rdata_o (first_rdata)
  );

  spa_term_ram #(
    .WIDTH (spa_pkg::TERM_W),
    .DEPTH (spa_pkg::MAX_TERMS)
  ) u_second_ram (
    .clk_i   (clk_i),
    .we_i    (we_second),
    .waddr_i (second_count_q[spa_pkg::IDX_W-1:0]),
    .wdata_i (wterm),
    .raddr_i (second_raddr),
    .rdata_o (second_rdata)
  );

  spa_merge_engine u_engine (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .ctrl_i         (ctrl),
    .status_o       (status),
    .first_raddr_o  (first_raddr),
    .second_raddr_o (second_raddr),
    .first_rdata_i  (spa_pkg::term_t'(first_rdata)),
    .second_rdata_i (spa_pkg::term_t'(second_rdata)),
    .rsp_o          (rsp_o)
  );

endmodule

FILE: design/spa_checker.sv
// port-level checker of the sparse polynomial adder and its bind
`timescale 1ns / 1ps
`include "sparse_polynomial_add_unit_assert.svh"

module spa_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        req_valid_i,
  input logic        req_ready_i,
  input logic [1:0]  req_action_i,
  input logic        rsp_valid_i,
  input logic        rsp_ready_i,
  input logic [16:0] rsp_coef_i,
  input logic [15:0] rsp_expo_i,
  input logic        rsp_term_i,
  input logic        rsp_last_i,
  input logic        rsp_ovf_i
);

  logic run_xfer;
  logic rsp_stall;

  assign run_xfer  = req_valid_i && req_ready_i && (req_action_i == spa_pkg::ACT_RUN);
  assign rsp_stall = rsp_valid_i && !rsp_ready_i;

  // a stalled result stays offered
  `SPA_ASSERT_NEXT(a_rsp_hold, clk_i, rst_ni, rsp_stall, rsp_valid_i)

  // a stalled result keeps its payload
  `SPA_ASSERT_NEXT(a_rsp_stable, clk_i, rst_ni, rsp_stall,
    $stable(rsp_coef_i) && $stable(rsp_expo_i) && $stable(rsp_term_i) &&
    $stable(rsp_last_i) && $stable(rsp_ovf_i))

  // no new item is taken while a run is merging
  `SPA_ASSERT_NEXT(a_run_blocks, clk_i, rst_ni, run_xfer, !req_ready_i)

  // an empty result only ever closes a run
  `SPA_ASSERT_SAME(a_empty_last, clk_i, rst_ni, rsp_valid_i && !rsp_term_i, rsp_last_i)

endmodule

bind sparse_polynomial_add_unit spa_checker u_spa_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .req_valid_i  (req_i.valid),
  .req_ready_i  (req_i.ready),
  .req_action_i (req_i.action),
  .rsp_valid_i  (rsp_o.valid),
  .rsp_ready_i  (rsp_o.ready),
  .rsp_coef_i   (rsp_o.sum_coefficient),
  .rsp_expo_i   (rsp_o.result_exponent),
  .rsp_term_i   (rsp_o.term_valid),
  .rsp_last_i   (rsp_o.last_term),
  .rsp_ovf_i    (rsp_o.load_overflow)
);
